>>> hdl/mmm_pkg.sv
package mmm_pkg;

	localparam int WORD_W     = 32;
	localparam int WC_W       = 7;
	localparam int CFG_ADDR_W = 2;

	localparam logic [CFG_ADDR_W-1:0] REG_WORD_COUNT = 2'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_NPRIME     = 2'd1;

	localparam logic [WC_W-1:0]   WC_RESET     = 7'd64;
	localparam logic [WORD_W-1:0] NPRIME_RESET = 32'd1;

	typedef enum logic [8:0] {
		ST_LOAD   = 9'b000000001,
		ST_MUL    = 9'b000000010,
		ST_RED    = 9'b000000100,
		ST_FLUSH  = 9'b000001000,
		ST_CMP    = 9'b000010000,
		ST_CMPEND = 9'b000100000,
		ST_ORD    = 9'b001000000,
		ST_ODATA  = 9'b010000000,
		ST_OSEND  = 9'b100000000
	} state_t;

	typedef enum logic [1:0] {
		OP_SCALE_A,
		OP_SCALE_U,
		OP_ELEM,
		OP_CMP
	} op_t;

endpackage

>>> hdl/mmm_mac.sv
module mmm_mac (
	input  logic [mmm_pkg::WORD_W-1:0]   x,
	input  logic [mmm_pkg::WORD_W-1:0]   y,
	input  logic [mmm_pkg::WORD_W-1:0]   z,
	input  logic [mmm_pkg::WORD_W-1:0]   c,
	output logic [2*mmm_pkg::WORD_W-1:0] t
);
	import mmm_pkg::*;

	logic [2*WORD_W-1:0] prod;

	// x*y + z + c never exceeds the double word
	assign prod = {{WORD_W{1'b0}}, x} * {{WORD_W{1'b0}}, y};
	assign t    = prod + {{WORD_W{1'b0}}, z} + {{WORD_W{1'b0}}, c};

endmodule

>>> hdl/montgomery_modular_multiply.sv
// Montgomery multiplier on 32-bit words: load word_count words (a, b and modulus N,
// least significant first, one word per cycle), then the block drops s_axis_tready and
// returns a*b*R^-1 mod N, R = 2^(32*len), as len words with tlast on the final one.
// A single 32x32 multiply-add unit does every multiply-add: len product rows, then len
// reduction rows, then a compare against N from the top word down, then the output
// words, each with N subtracted if the result is not below N; the block waits while
// m_axis_tready is held low.
// word_count 0 acts as 1, above MAX_WORDS as MAX_WORDS; writing it restarts the load.
// Configure only while no run is in progress. Operands are expected below N.
module montgomery_modular_multiply #(
	parameter int MAX_WORDS = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [mmm_pkg::CFG_ADDR_W-1:0]    cfg_addr,
	input  logic [mmm_pkg::WORD_W-1:0]        cfg_wdata,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [3*mmm_pkg::WORD_W-1:0]      s_axis_tdata,  // a_word, b_word, modulus_word
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	output logic [mmm_pkg::WORD_W-1:0]        m_axis_tdata,  // result_word
	output logic                              m_axis_tlast
);
	import mmm_pkg::*;

	localparam int AW  = $clog2(MAX_WORDS);
	localparam int LW  = $clog2(MAX_WORDS + 1);
	localparam int CAW = $clog2(2 * MAX_WORDS);

	state_t              state_q;
	logic [WC_W-1:0]     wc_q;
	logic [WORD_W-1:0]   nprime_q;
	logic [LW-1:0]       load_q;
	logic [AW-1:0]       row_q;
	logic [CAW-1:0]      j_q;
	logic                pre_q;
	logic [AW-1:0]       k_q;
	logic [WORD_W-1:0]   top_q;
	logic [WORD_W-1:0]   carry_q;
	logic [WORD_W-1:0]   scale_q;
	logic                ge_q;
	logic                dec_q;
	logic                borrow_q;
	logic                out_valid_q;
	logic [WORD_W-1:0]   out_data_q;
	logic                out_last_q;

	logic [WORD_W-1:0]   a_mem [MAX_WORDS];
	logic [WORD_W-1:0]   b_mem [MAX_WORDS];
	logic [WORD_W-1:0]   n_mem [MAX_WORDS];
	logic [WORD_W-1:0]   acc_mem [2*MAX_WORDS];
	logic [WORD_W-1:0]   a_rd_q, b_rd_q, n_rd_q, acc_rd_q;

	logic                valid_s1;
	op_t                 op_s1;
	logic [CAW-1:0]      waddr_s1;
	logic                first_s1, zvec_s1, zacc_s1, red_s1, top_s1;

	logic [LW-1:0]       len_c;
	logic [CAW-1:0]      len_x, row_x, sum_c;
	logic [LW-1:0]       idx_c, nxt_c;
	logic                accept_c;
	logic                row_end_c;

	logic [AW-1:0]       a_ra, vec_ra;
	logic [CAW-1:0]      acc_ra;
	logic                iss_valid, iss_first, iss_zvec, iss_zacc, iss_top;
	op_t                 iss_op;

	logic [WORD_W-1:0]   mac_x, mac_y, mac_z, mac_c;
	logic [2*WORD_W-1:0] mac_t;
	logic                sub_c;
	logic [WORD_W:0]     diff_c;

	assign len_c = (wc_q == '0) ? LW'(1) :
	               (wc_q > WC_W'(MAX_WORDS)) ? LW'(MAX_WORDS) : LW'(wc_q);
	assign len_x = CAW'(len_c);
	assign row_x = CAW'(row_q);
	assign sum_c = row_x + j_q;

	assign s_axis_tready = (state_q == ST_LOAD);
	assign accept_c      = s_axis_tvalid && s_axis_tready;
	assign idx_c         = (load_q >= len_c) ? '0 : load_q;
	assign nxt_c         = idx_c + LW'(1);

	assign row_end_c = (state_q == ST_MUL) ? (j_q == len_x)
	                                       : (sum_c == len_x + len_x - CAW'(1));

	// issue: pick memory addresses and the operation for the next multiply-add or compare step
	always_comb begin
		a_ra      = row_q;
		vec_ra    = (j_q < len_x) ? j_q[AW-1:0] : '0;
		acc_ra    = sum_c;
		iss_valid = 1'b0;
		iss_op    = OP_ELEM;
		iss_first = (j_q == '0);
		iss_zvec  = 1'b0;
		iss_zacc  = 1'b0;
		iss_top   = 1'b0;
		unique case (state_q)
			ST_MUL: begin
				iss_valid = 1'b1;
				if (pre_q) begin
					iss_op = OP_SCALE_A;
				end else begin
					iss_zvec = (j_q == len_x);
					iss_zacc = (row_q == '0) || (j_q == len_x);
				end
			end
			ST_RED: begin
				iss_valid = 1'b1;
				if (pre_q) begin
					iss_op = OP_SCALE_U;
					acc_ra = row_x;
				end else begin
					iss_zvec = (j_q >= len_x);
					iss_top  = row_end_c;
				end
			end
			ST_CMP: begin
				iss_valid = 1'b1;
				iss_op    = OP_CMP;
				acc_ra    = len_x + CAW'(k_q);
				vec_ra    = k_q;
			end
			ST_ORD: begin
				acc_ra = len_x + CAW'(k_q);
				vec_ra = k_q;
			end
			default: begin
			end
		endcase
	end

	// operand stores
	always_ff @(posedge clk) begin
		if (accept_c) begin
			a_mem[idx_c[AW-1:0]] <= s_axis_tdata[WORD_W-1:0];
			b_mem[idx_c[AW-1:0]] <= s_axis_tdata[2*WORD_W-1:WORD_W];
			n_mem[idx_c[AW-1:0]] <= s_axis_tdata[3*WORD_W-1:2*WORD_W];
		end
		a_rd_q <= a_mem[a_ra];
		b_rd_q <= b_mem[vec_ra];
		n_rd_q <= n_mem[vec_ra];
	end

	// accumulator
	always_ff @(posedge clk) begin
		if (valid_s1 && op_s1 == OP_ELEM)
			acc_mem[waddr_s1] <= mac_t[WORD_W-1:0];
		acc_rd_q <= acc_mem[acc_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= iss_valid;
		end
	end

	always_ff @(posedge clk) begin
		op_s1    <= iss_op;
		waddr_s1 <= sum_c;
		first_s1 <= iss_first;
		zvec_s1  <= iss_zvec;
		zacc_s1  <= iss_zacc;
		red_s1   <= (state_q == ST_RED);
		top_s1   <= iss_top;
	end

	always_comb begin
		mac_x = scale_q;
		mac_y = zvec_s1 ? '0 : (red_s1 ? n_rd_q : b_rd_q);
		mac_z = zacc_s1 ? '0 : acc_rd_q;
		mac_c = first_s1 ? '0 : carry_q;
		if (op_s1 == OP_SCALE_U) begin
			mac_x = acc_rd_q;
			mac_y = nprime_q;
			mac_z = '0;
			mac_c = '0;
		end
	end

	mmm_mac u_mac (
		.x(mac_x),
		.y(mac_y),
		.z(mac_z),
		.c(mac_c),
		.t(mac_t)
	);

	assign sub_c  = (top_q != '0) || ge_q;
	assign diff_c = {1'b0, acc_rd_q} - {1'b0, n_rd_q} - {{WORD_W{1'b0}}, borrow_q};

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept_c && nxt_c == len_c)
			top_q <= '0;
		if (valid_s1) begin
			case (op_s1)
				OP_SCALE_A: scale_q <= a_rd_q;
				OP_SCALE_U: scale_q <= mac_t[WORD_W-1:0];
				OP_ELEM: begin
					carry_q <= mac_t[2*WORD_W-1:WORD_W];
					if (top_s1)
						top_q <= top_q + mac_t[2*WORD_W-1:WORD_W];
				end
				default: begin
					if (!dec_q && acc_rd_q != n_rd_q) begin
						dec_q <= 1'b1;
						ge_q  <= (acc_rd_q > n_rd_q);
					end
				end
			endcase
		end
		if (state_q == ST_FLUSH) begin
			dec_q <= 1'b0;
			ge_q  <= 1'b1;
		end
		if (state_q == ST_CMPEND)
			borrow_q <= 1'b0;
		if (state_q == ST_ODATA) begin
			out_data_q <= sub_c ? diff_c[WORD_W-1:0] : acc_rd_q;
			out_last_q <= (CAW'(k_q) + CAW'(1) == len_x);
			borrow_q   <= diff_c[WORD_W];
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			wc_q        <= WC_RESET;
			nprime_q    <= NPRIME_RESET;
			load_q      <= '0;
			row_q       <= '0;
			j_q         <= '0;
			pre_q       <= 1'b1;
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_LOAD: begin
					if (accept_c) begin
						if (nxt_c == len_c) begin
							state_q <= ST_MUL;
							load_q  <= '0;
							row_q   <= '0;
							pre_q   <= 1'b1;
						end else begin
							load_q <= nxt_c;
						end
					end
				end
				ST_MUL, ST_RED: begin
					if (pre_q) begin
						pre_q <= 1'b0;
						j_q   <= '0;
					end else if (row_end_c) begin
						pre_q <= 1'b1;
						j_q   <= '0;
						if (row_x + CAW'(1) == len_x) begin
							row_q   <= '0;
							state_q <= (state_q == ST_MUL) ? ST_RED : ST_FLUSH;
						end else begin
							row_q <= row_q + AW'(1);
						end
					end else begin
						j_q <= j_q + CAW'(1);
					end
				end
				ST_FLUSH: begin
					state_q <= ST_CMP;
					k_q     <= AW'(len_c - LW'(1));
				end
				ST_CMP: begin
					if (k_q == '0)
						state_q <= ST_CMPEND;
					else
						k_q <= k_q - AW'(1);
				end
				ST_CMPEND: begin
					state_q <= ST_ORD;
					k_q     <= '0;
				end
				ST_ORD: begin
					state_q <= ST_ODATA;
				end
				ST_ODATA: begin
					out_valid_q <= 1'b1;
					state_q     <= ST_OSEND;
				end
				ST_OSEND: begin
					if (m_axis_tready) begin
						out_valid_q <= 1'b0;
						if (out_last_q) begin
							state_q <= ST_LOAD;
						end else begin
							k_q     <= k_q + AW'(1);
							state_q <= ST_ORD;
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
			if (cfg_we && cfg_addr == REG_WORD_COUNT) begin
				wc_q   <= cfg_wdata[WC_W-1:0];
				load_q <= '0;
			end
			if (cfg_we && cfg_addr == REG_NPRIME)
				nprime_q <= cfg_wdata;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tlast  = out_last_q;

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !s_axis_tready)
		else $error("result word offered while loading");

	a_last_reloads: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && m_axis_tlast |=> s_axis_tready)
		else $error("block not back to loading after last word");

	a_load_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOAD) |-> (load_q < len_c))
		else $error("load index beyond length");

	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL || state_q == ST_RED) |-> (row_x < len_x))
		else $error("row index beyond length");

endmodule
